[rtl/wbrm_pkg.sv]
// Package: shared constants and controller/datapath interface types for the byte rate meter.
`default_nettype none

package wbrm_pkg;

    // Ring geometry
    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int TIME_W = DATA_W + ((DEPTH > 1) ? $clog2(DEPTH) : 0);

    // Divider: dividend is bytes << 16, remainder carries one guard bit
    localparam int DVD_W  = DATA_W + FRAC_W;
    localparam int REM_W  = TIME_W + 1;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);

    typedef struct packed {
        logic capture;    // latch input transaction, form deltas
        logic update;     // update window sums, write rings
        logic div_start;  // load both dividers
        logic div_step;   // one quotient bit per divider
        logic out_load;   // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;   // current step is the last quotient bit
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/wbrm_ctrl.sv]
// Controller: sequences capture, window update, division and result handoff.
`default_nettype none

module wbrm_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output wbrm_pkg::t_dp_cmd    o_cmd,
    input  wbrm_pkg::t_dp_status i_status
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_SETUP  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/wbrm_dp.sv]
// Datapath: delta capture, sample rings, window sums and two radix-2 dividers.
`default_nettype none

module wbrm_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [3*wbrm_pkg::DATA_W-1:0]      i_in_data,
    input  wbrm_pkg::t_dp_cmd                  i_cmd,
    output wbrm_pkg::t_dp_status               o_status,
    output logic [2*wbrm_pkg::DATA_W-1:0]      o_out_data,
    output logic                               o_out_sat
);

    localparam int DW = wbrm_pkg::DATA_W;
    localparam int TW = wbrm_pkg::TIME_W;
    localparam int QW = wbrm_pkg::DVD_W;
    localparam int RW = wbrm_pkg::REM_W;

    // Captured tick
    logic [DW-1:0] r_prev_sent, r_prev_recv;
    logic [DW-1:0] r_d_sent, r_d_recv, r_dt;

    // Rings; an entry never written reads as zero
    logic [DW-1:0] r_sent_ring [wbrm_pkg::DEPTH];
    logic [DW-1:0] r_recv_ring [wbrm_pkg::DEPTH];
    logic [DW-1:0] r_time_ring [wbrm_pkg::DEPTH];
    logic [wbrm_pkg::DEPTH-1:0] r_valid;
    logic [wbrm_pkg::PTR_W-1:0] r_pos;

    logic [DW-1:0] old_sent, old_recv, old_time;

    // Window sums
    logic [DW-1:0] r_sent_sum, r_recv_sum;
    logic [TW-1:0] r_time_sum;

    // Dividers
    logic [QW-1:0] r_q_sent, r_q_recv;
    logic [RW-1:0] r_rem_sent, r_rem_recv;
    logic [RW-1:0] trial_sent, trial_recv;
    logic [RW-1:0] div_ext;
    logic          ge_sent, ge_recv;
    logic [wbrm_pkg::CNT_W-1:0] r_cnt;

    logic          time_zero, ovf_sent, ovf_recv;

    assign old_sent = r_valid[r_pos] ? r_sent_ring[r_pos] : '0;
    assign old_recv = r_valid[r_pos] ? r_recv_ring[r_pos] : '0;
    assign old_time = r_valid[r_pos] ? r_time_ring[r_pos] : '0;

    assign o_status.div_done = (r_cnt == wbrm_pkg::LAST_STEP);

    // Restoring step: shift in next dividend bit, subtract if it fits
    assign div_ext    = {1'b0, r_time_sum};
    assign trial_sent = {r_rem_sent[RW-2:0], r_q_sent[QW-1]};
    assign trial_recv = {r_rem_recv[RW-2:0], r_q_recv[QW-1]};
    assign ge_sent    = (trial_sent >= div_ext);
    assign ge_recv    = (trial_recv >= div_ext);

    assign time_zero = (r_time_sum == '0);
    assign ovf_sent  = |r_q_sent[QW-1:DW];
    assign ovf_recv  = |r_q_recv[QW-1:DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sent <= '0;
            r_prev_recv <= '0;
            r_valid     <= '0;
            r_pos       <= '0;
            r_sent_sum  <= '0;
            r_recv_sum  <= '0;
            r_time_sum  <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_prev_sent <= i_in_data[DW-1:0];
                r_prev_recv <= i_in_data[2*DW-1:DW];
            end
            if (i_cmd.update) begin
                r_sent_sum     <= r_sent_sum - old_sent + r_d_sent;
                r_recv_sum     <= r_recv_sum - old_recv + r_d_recv;
                r_time_sum     <= r_time_sum - TW'(old_time) + TW'(r_dt);
                r_valid[r_pos] <= 1'b1;
                r_pos          <= (r_pos == wbrm_pkg::LAST_POS) ? '0
                                  : r_pos + wbrm_pkg::PTR_W'(1);
            end
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + wbrm_pkg::CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_d_sent <= i_in_data[DW-1:0] - r_prev_sent;
            r_d_recv <= i_in_data[2*DW-1:DW] - r_prev_recv;
            r_dt     <= i_in_data[3*DW-1:2*DW];
        end
        if (i_cmd.update) begin
            r_sent_ring[r_pos] <= r_d_sent;
            r_recv_ring[r_pos] <= r_d_recv;
            r_time_ring[r_pos] <= r_dt;
        end
        if (i_cmd.div_start) begin
            r_q_sent   <= {r_sent_sum, {wbrm_pkg::FRAC_W{1'b0}}};
            r_q_recv   <= {r_recv_sum, {wbrm_pkg::FRAC_W{1'b0}}};
            r_rem_sent <= '0;
            r_rem_recv <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_sent <= ge_sent ? trial_sent - div_ext : trial_sent;
            r_rem_recv <= ge_recv ? trial_recv - div_ext : trial_recv;
            r_q_sent   <= {r_q_sent[QW-2:0], ge_sent};
            r_q_recv   <= {r_q_recv[QW-2:0], ge_recv};
        end
        if (i_cmd.out_load) begin
            o_out_data[DW-1:0]    <= (time_zero || ovf_sent) ? '1 : r_q_sent[DW-1:0];
            o_out_data[2*DW-1:DW] <= (time_zero || ovf_recv) ? '1 : r_q_recv[DW-1:0];
            o_out_sat             <= time_zero || ovf_sent || ovf_recv;
        end
    end

endmodule

`default_nettype wire

[rtl/windowed_byte_rate_meter_unit.sv]
// Top level: sliding-window sent/received byte rate meter.
//
//  channel  dir  payload (low bit first)                         meaning
//  s_axis   in   tdata: sent_total[31:0], received_total[31:0],  one tick
//                       tick_time[31:0] (Q16.16 s)
//  m_axis   out  tdata: sent_rate[31:0], received_rate[31:0];    window rates, bytes/s
//                tuser: saturated
//
// The result register loads after window update, divider load and two parallel restoring
// dividers (one quotient bit per cycle over the 48-bit bytes<<16 dividend), then handoff;
// the next tick is taken in the cycle after the handoff.
// s_axis_tready is high only while the unit is idle; the output register lets the
// next tick start while a result waits, and a finished result waits until the output register is free.
// Reset (i_rst_n low, synchronous) clears totals, sums, ring valid bits and handshakes.
`default_nettype none

module windowed_byte_rate_meter_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // sent_total, received_total, tick_time
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sent_rate, received_rate
    output logic        m_axis_tuser    // saturated
);

    wbrm_pkg::t_dp_cmd    cmd;
    wbrm_pkg::t_dp_status status;

    // Sequencer: one tick in flight, output register decoupled from input side
    wbrm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    // Rings, running sums and dividers
    wbrm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (s_axis_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (m_axis_tdata),
        .o_out_sat  (m_axis_tuser)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the windowed byte rate meter: streamed ticks vs. a rate predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_TICKS   = 1500;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
    localparam int DRAIN_CYCLES   = 120;   // > one full tick latency

    // s_axis tdata layout, lowest bits first: sent_total, received_total, tick_time
    typedef struct packed {
        logic [31:0] tick_time;
        logic [31:0] received_total;
        logic [31:0] sent_total;
    } t_tick;

    typedef struct {
        logic [31:0] sent_rate;
        logic [31:0] received_rate;
        logic        saturated;
    } t_rates;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    t_tick       s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;     // sent_rate, received_rate
    logic        m_axis_tuser;     // saturated

    windowed_byte_rate_meter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Rate predictor: window history, running sums, last totals
    // ---------------------------------------------------------------
    logic [31:0] sent_hist [wbrm_pkg::DEPTH] = '{default: '0};
    logic [31:0] recv_hist [wbrm_pkg::DEPTH] = '{default: '0};
    logic [31:0] span_hist [wbrm_pkg::DEPTH] = '{default: '0};
    int          hist_slot   = 0;
    logic [31:0] last_sent   = '0;
    logic [31:0] last_recv   = '0;
    logic [31:0] sent_sum    = '0;   // wraps mod 2^32
    logic [31:0] recv_sum    = '0;   // wraps mod 2^32
    logic [63:0] span_sum    = '0;   // exact window time

    // {saturated, rate}: floor(bytes * 2^16 / span), clamped
    function automatic logic [32:0] bytes_per_second(logic [31:0] bytes, logic [63:0] span);
        logic [63:0] quotient;
        if (span == 64'd0)
            return {1'b1, 32'hFFFF_FFFF};
        quotient = {16'h0, bytes, 16'h0} / span;
        if (quotient[63:32] != 32'd0)
            return {1'b1, 32'hFFFF_FFFF};
        return {1'b0, quotient[31:0]};
    endfunction

    function automatic t_rates window_rate_update(t_tick tick);
        logic [31:0] d_sent;
        logic [31:0] d_recv;
        logic [32:0] sent_q;
        logic [32:0] recv_q;
        t_rates      res;
        d_sent   = tick.sent_total - last_sent;
        d_recv   = tick.received_total - last_recv;
        sent_sum = sent_sum - sent_hist[hist_slot] + d_sent;
        recv_sum = recv_sum - recv_hist[hist_slot] + d_recv;
        span_sum = span_sum - {32'h0, span_hist[hist_slot]} + {32'h0, tick.tick_time};
        sent_hist[hist_slot] = d_sent;
        recv_hist[hist_slot] = d_recv;
        span_hist[hist_slot] = tick.tick_time;
        hist_slot = (hist_slot == wbrm_pkg::DEPTH - 1) ? 0 : hist_slot + 1;
        last_sent = tick.sent_total;
        last_recv = tick.received_total;
        sent_q = bytes_per_second(sent_sum, span_sum);
        recv_q = bytes_per_second(recv_sum, span_sum);
        res.sent_rate     = sent_q[31:0];
        res.received_rate = recv_q[31:0];
        res.saturated     = sent_q[32] | recv_q[32];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus queue and bookkeeping
    // ---------------------------------------------------------------
    t_tick       pending_ticks [$];
    t_rates      expected_rates [$];
    logic [31:0] stim_sent      = '0;
    logic [31:0] stim_recv      = '0;
    int          total_ticks    = 0;
    int          accepted_ticks = 0;
    int          error_count    = 0;
    int          quiet_cycles   = 0;
    int          sender_idle    = 10;
    int          receiver_idle  = 45;
    bit          tick_accepted  = 1'b0;

    task automatic queue_tick(logic [31:0] sent, logic [31:0] recv, logic [31:0] span);
        t_tick t;
        t.sent_total     = sent;
        t.received_total = recv;
        t.tick_time      = span;
        pending_ticks = {pending_ticks, t};
        stim_sent = sent;
        stim_recv = recv;
    endtask

    // Driver: new tick presented at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || tick_accepted) begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
                s_axis_tdata  <= pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= receiver_idle);
    end

    // Monitor: predict on accepted ticks, check every accepted result
    always @(posedge i_clk) begin
        t_rates exp_r;
        tick_accepted = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rates.size() == 0) begin
                    $error("unexpected result: sent_rate %h received_rate %h saturated %b",
                           m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
                    error_count++;
                end else begin
                    exp_r = expected_rates.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.sent_rate) begin
                        $error("sent_rate: expected %h, actual %h",
                               exp_r.sent_rate, m_axis_tdata[31:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[63:32] !== exp_r.received_rate) begin
                        $error("received_rate: expected %h, actual %h",
                               exp_r.received_rate, m_axis_tdata[63:32]);
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_r.saturated) begin
                        $error("saturated: expected %b, actual %b",
                               exp_r.saturated, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            if (tick_accepted) begin
                expected_rates = {expected_rates, window_rate_update(s_axis_tdata)};
                accepted_ticks++;
            end
            if (tick_accepted || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            // stall profile: sender-light, then receiver-light, then free running
            if (accepted_ticks < total_ticks / 3) begin
                sender_idle   = 10;
                receiver_idle = 45;
            end else if (accepted_ticks < (2 * total_ticks) / 3) begin
                sender_idle   = 45;
                receiver_idle = 10;
            end else begin
                sender_idle   = 0;
                receiver_idle = 0;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int          seg;
        int          len;
        int          target;
        logic [31:0] max_step;
        logic [31:0] max_span;

        // Directed: first tick counts whole totals, zero window time
        queue_tick(32'h0000_1234, 32'h0000_0056, 32'h0);
        queue_tick(32'h0000_2234, 32'h0000_0156, 32'h0000_0100);
        // sent quotient overflows alone, received still reported
        queue_tick(32'h8000_2234, 32'h0000_0157, 32'h0000_0001);
        // both quotients overflow
        queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        // totals wrap below the previous value
        queue_tick(32'h0000_0010, 32'h0000_0005, 32'h0001_0000);
        queue_tick(32'h7FFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        // fill and roll the window with maximal ticks; byte sums wrap
        for (int i = 0; i < wbrm_pkg::DEPTH; i++)
            queue_tick(stim_sent + 32'h9234_5678, stim_recv + 32'hF000_0001, 32'hFFFF_FFFF);
        queue_tick(stim_sent, stim_recv, 32'h0);

        target = pending_ticks.size() + RANDOM_TICKS;
        while (pending_ticks.size() < target) begin
            seg = $urandom_range(0, 11);
            if (seg <= 5) begin
                // steady traffic with bounded increments
                len = $urandom_range(8, 40);
                case ($urandom_range(0, 3))
                    0: max_step = 32'h0000_00FF;
                    1: max_step = 32'h0000_FFFF;
                    2: max_step = 32'h00FF_FFFF;
                    default: max_step = 32'hFFFF_FFFF;
                endcase
                case ($urandom_range(0, 3))
                    0: max_span = 32'h0000_0040;
                    1: max_span = 32'h0000_1000;
                    2: max_span = 32'h0010_0000;
                    default: max_span = 32'hFFFF_FFFF;
                endcase
                for (int i = 0; i < len; i++)
                    queue_tick(stim_sent + $urandom_range(0, max_step),
                               stim_recv + $urandom_range(0, max_step),
                               $urandom_range(1, max_span));
            end else if (seg <= 7) begin
                // unrelated totals and durations
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    queue_tick($urandom(), $urandom(), $urandom());
            end else if (seg == 8) begin
                // window time drains to zero
                len = $urandom_range(wbrm_pkg::DEPTH, wbrm_pkg::DEPTH + 8);
                for (int i = 0; i < len; i++)
                    queue_tick(stim_sent + $urandom_range(0, 255),
                               stim_recv + $urandom_range(0, 255), 32'h0);
            end else if (seg == 9) begin
                // near-maximal durations, widest time sum
                len = $urandom_range(wbrm_pkg::DEPTH, wbrm_pkg::DEPTH + 8);
                for (int i = 0; i < len; i++)
                    queue_tick(stim_sent + $urandom(), stim_recv + $urandom(),
                               $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF));
            end else begin
                // tiny durations, sent quotient overflows
                len = $urandom_range(4, 20);
                for (int i = 0; i < len; i++)
                    queue_tick(stim_sent + $urandom(),
                               stim_recv + $urandom_range(0, 15),
                               $urandom_range(0, 3));
            end
        end
        total_ticks = pending_ticks.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_ticks < total_ticks)
            @(posedge i_clk);
        while (expected_rates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
